// ----- rtl/sab_pkg.sv -----
// ----------------------------------------------------------------------------
// sab_pkg: shared types and constants of the suffix automaton builder
// Table sizes, field widths, controller state codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int MAX_LEN    = 4096;
    localparam int ALPHABET   = 26;
    localparam int MAX_STATES = 2 * MAX_LEN;
    localparam int T_DEPTH    = MAX_STATES * ALPHABET;

    localparam int SW  = 14;                  // state id, with room for "none"
    localparam int IW  = $clog2(MAX_STATES);  // state index into tables
    localparam int LW  = 13;                  // string length
    localparam int TW  = 24;                  // running total
    localparam int AW  = $clog2(T_DEPTH);     // transition table address
    localparam int CW  = 5;                   // symbol width
    localparam int XW  = 5;                   // row column counter, holds ALPHABET

    localparam logic [SW-1:0] NO_STATE = '1;

    // controller states, one-hot
    typedef enum logic [12:0] {
        ST_INIT  = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_CLRP  = 13'b0000000000100,
        ST_W1RD  = 13'b0000000001000,
        ST_W1CHK = 13'b0000000010000,
        ST_CMP   = 13'b0000000100000,
        ST_COPY  = 13'b0000001000000,
        ST_W2RD  = 13'b0000010000000,
        ST_W2CHK = 13'b0000100000000,
        ST_FIN1  = 13'b0001000000000,
        ST_FIN2  = 13'b0010000000000,
        ST_SUM   = 13'b0100000000000,
        ST_DONE  = 13'b1000000000000
    } t_state;

    typedef struct packed {
        t_state op;       // step the datapath carries out this cycle
        logic   accept;   // input transfer this cycle
    } t_cmd;

    typedef struct packed {
        logic take;       // accepted symbol extends the automaton
        logic v_none;     // walk pointer reached past the root
        logic edge_none;  // read transition is absent
        logic edge_is_u;  // read transition points at the split state
        logic len_match;  // len(v)+1 == len(u), no clone
        logic idx_last;   // row clear at last column
        logic idx_full;   // row copy finished
        logic out_free;   // output register can be loaded
    } t_stat;

    // row base: state * 26 by shift and add
    function automatic logic [AW-1:0] row_base(input logic [IW-1:0] s);
        logic [AW-1:0] e;
        e = AW'(s);
        return (e << 4) + (e << 3) + (e << 1);
    endfunction

endpackage

// ----- rtl/sab_ctrl.sv -----
// ----------------------------------------------------------------------------
// sab_ctrl: sequencer of the suffix automaton builder
// Steps through row clear, suffix-link walks, clone copy and result load.
// ----------------------------------------------------------------------------
module sab_ctrl
    import sab_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    assign o_ready      = (r_state == ST_IDLE);
    assign o_cmd.op     = r_state;
    assign o_cmd.accept = i_valid && (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:  if (i_stat.idx_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_valid) n_state = i_stat.take ? ST_CLRP : ST_DONE;
            end
            ST_CLRP:  if (i_stat.idx_last) n_state = ST_W1RD;
            ST_W1RD:  n_state = i_stat.v_none ? ST_SUM : ST_W1CHK;
            ST_W1CHK: n_state = i_stat.edge_none ? ST_W1RD : ST_CMP;
            ST_CMP:   n_state = i_stat.len_match ? ST_SUM : ST_COPY;
            ST_COPY:  if (i_stat.idx_full) n_state = ST_W2RD;
            ST_W2RD:  n_state = i_stat.v_none ? ST_FIN1 : ST_W2CHK;
            ST_W2CHK: n_state = i_stat.edge_is_u ? ST_W2RD : ST_FIN1;
            ST_FIN1:  n_state = ST_FIN2;
            ST_FIN2:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_DONE;
            ST_DONE:  if (i_stat.out_free) n_state = ST_IDLE;
            default:  n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_INIT;
        else          r_state <= n_state;
    end

endmodule

// ----- rtl/sab_datapath.sv -----
// ----------------------------------------------------------------------------
// sab_datapath: tables and working registers of the suffix automaton builder
// Holds link, length and transition memories, walk pointers and the
// output register; carries out the step the controller selects.
// ----------------------------------------------------------------------------
module sab_datapath
    import sab_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    input  logic [CW-1:0] i_symbol,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [TW-1:0] o_distinct_substrings,
    output logic          o_full_res
);

    // memories
    logic [SW-1:0] trans_mem [T_DEPTH];
    logic [SW-1:0] link_mem  [MAX_STATES];
    logic [LW-1:0] len_mem   [MAX_STATES];

    logic          t_we, k_we, l_we;
    logic [AW-1:0] t_wa, t_ra;
    logic [IW-1:0] k_wa, k_ra, l_wa, l_ra;
    logic [SW-1:0] t_wd, k_wd, t_q, k_q;
    logic [LW-1:0] l_wd, l_q;

    // working registers
    logic [SW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_last, n_last;
    logic [TW-1:0] r_total, n_total;
    logic [LW-1:0] r_seen, n_seen;
    logic [XW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_p, n_p, r_u, n_u, r_w, n_w;
    logic [SW-1:0] r_v, n_v;
    logic [CW-1:0] r_c, n_c;
    logic [AW-1:0] r_pbase, n_pbase, r_ubase, n_ubase, r_wbase, n_wbase;
    logic [AW-1:0] r_vaddr, n_vaddr;
    logic [LW-1:0] r_lenp, n_lenp, r_lenv, n_lenv, r_lenl, n_lenl;
    logic          r_full, n_full;
    logic          r_ovalid, n_ovalid;
    logic [TW-1:0] r_odist, n_odist;
    logic          r_ofull, n_ofull;

    logic [AW-1:0] v_addr;
    logic [LW-1:0] lenv_inc;

    assign v_addr   = row_base(r_v[IW-1:0]) + AW'(r_c);
    assign lenv_inc = r_lenv + LW'(1);

    // status toward the controller
    assign o_stat.take      = (i_symbol < CW'(ALPHABET)) && (r_seen < LW'(MAX_LEN));
    assign o_stat.v_none    = (r_v == NO_STATE);
    assign o_stat.edge_none = (t_q == NO_STATE);
    assign o_stat.edge_is_u = (t_q == SW'(r_u));
    assign o_stat.len_match = (lenv_inc == l_q);
    assign o_stat.idx_last  = (r_idx == XW'(ALPHABET - 1));
    assign o_stat.idx_full  = (r_idx == XW'(ALPHABET));
    assign o_stat.out_free  = !r_ovalid || i_ready;

    // step decode
    always_comb begin
        t_we = 1'b0; t_wa = '0; t_wd = NO_STATE; t_ra = v_addr;
        k_we = 1'b0; k_wa = '0; k_wd = NO_STATE; k_ra = r_v[IW-1:0];
        l_we = 1'b0; l_wa = '0; l_wd = '0;       l_ra = r_last;
        n_cnt = r_cnt; n_last = r_last; n_total = r_total; n_seen = r_seen;
        n_idx = r_idx; n_p = r_p; n_u = r_u; n_w = r_w; n_v = r_v; n_c = r_c;
        n_pbase = r_pbase; n_ubase = r_ubase; n_wbase = r_wbase;
        n_vaddr = r_vaddr; n_lenp = r_lenp; n_lenv = r_lenv; n_lenl = r_lenl;
        n_full = r_full;
        n_ovalid = r_ovalid && !i_ready;
        n_odist = r_odist; n_ofull = r_ofull;
        case (i_cmd.op)
            // clear root row, set root link and length
            ST_INIT: begin
                t_we = 1'b1; t_wa = AW'(r_idx);
                k_we = 1'b1; k_wa = '0; k_wd = NO_STATE;
                l_we = 1'b1; l_wa = '0; l_wd = '0;
                n_idx = r_idx + XW'(1);
            end
            // new symbol: allocate state p, start read of len(last)
            ST_IDLE: begin
                if (i_cmd.accept) begin
                    n_idx  = '0;
                    n_full = 1'b0;
                    if (o_stat.take) begin
                        n_p     = r_cnt[IW-1:0];
                        n_pbase = row_base(r_cnt[IW-1:0]);
                        n_cnt   = r_cnt + SW'(1);
                        n_v     = SW'(r_last);
                        n_c     = i_symbol;
                    end else begin
                        n_full = (i_symbol < CW'(ALPHABET));
                    end
                end
            end
            // clear row p, write len(p) = len(last)+1
            ST_CLRP: begin
                t_we = 1'b1; t_wa = r_pbase + AW'(r_idx);
                l_we = 1'b1; l_wa = r_p; l_wd = l_q + LW'(1);
                n_lenp = l_q + LW'(1);
                n_idx  = r_idx + XW'(1);
            end
            // first walk: read edge, link and length of v
            ST_W1RD: begin
                l_ra = r_v[IW-1:0];
                n_vaddr = v_addr;
                if (o_stat.v_none) begin
                    k_we = 1'b1; k_wa = r_p; k_wd = '0;
                    n_lenl = '0;
                end
            end
            ST_W1CHK: begin
                if (o_stat.edge_none) begin
                    t_we = 1'b1; t_wa = r_vaddr; t_wd = SW'(r_p);
                    n_v  = k_q;
                end else begin
                    n_u     = t_q[IW-1:0];
                    n_ubase = row_base(t_q[IW-1:0]);
                    n_lenv  = l_q;
                    k_ra    = t_q[IW-1:0];
                    l_ra    = t_q[IW-1:0];
                end
            end
            // solid edge, or allocate clone w
            ST_CMP: begin
                if (o_stat.len_match) begin
                    k_we = 1'b1; k_wa = r_p; k_wd = SW'(r_u);
                    n_lenl = l_q;
                end else begin
                    n_w     = r_cnt[IW-1:0];
                    n_wbase = row_base(r_cnt[IW-1:0]);
                    n_cnt   = r_cnt + SW'(1);
                    l_we = 1'b1; l_wa = r_cnt[IW-1:0]; l_wd = lenv_inc;
                    k_we = 1'b1; k_wa = r_cnt[IW-1:0]; k_wd = k_q;
                    n_idx = '0;
                end
            end
            // copy row u to row w, read one column ahead of the write
            ST_COPY: begin
                t_ra = r_ubase + AW'(r_idx);
                if (r_idx != '0) begin
                    t_we = 1'b1; t_wa = r_wbase + AW'(r_idx - XW'(1)); t_wd = t_q;
                end
                n_idx = r_idx + XW'(1);
            end
            // second walk: redirect edges from u to w
            ST_W2RD: begin
                n_vaddr = v_addr;
            end
            ST_W2CHK: begin
                if (o_stat.edge_is_u) begin
                    t_we = 1'b1; t_wa = r_vaddr; t_wd = SW'(r_w);
                    n_v  = k_q;
                end
            end
            ST_FIN1: begin
                k_we = 1'b1; k_wa = r_p; k_wd = SW'(r_w);
                n_lenl = lenv_inc;
            end
            ST_FIN2: begin
                k_we = 1'b1; k_wa = r_u; k_wd = SW'(r_w);
            end
            // running total of len(p) - len(link(p))
            ST_SUM: begin
                n_total = r_total + TW'(r_lenp - r_lenl);
                n_last  = r_p;
                n_seen  = r_seen + LW'(1);
            end
            // load the output register
            ST_DONE: begin
                if (o_stat.out_free) begin
                    n_ovalid = 1'b1;
                    n_odist  = r_total;
                    n_ofull  = r_full;
                end
            end
            default: ;
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (t_we) trans_mem[t_wa] <= t_wd;
        t_q <= trans_mem[t_ra];
    end

    always_ff @(posedge i_clk) begin
        if (k_we) link_mem[k_wa] <= k_wd;
        k_q <= link_mem[k_ra];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) len_mem[l_wa] <= l_wd;
        l_q <= len_mem[l_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= SW'(1);
            r_last   <= '0;
            r_total  <= '0;
            r_seen   <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_total  <= n_total;
            r_seen   <= n_seen;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p <= n_p; r_u <= n_u; r_w <= n_w; r_v <= n_v; r_c <= n_c;
        r_pbase <= n_pbase; r_ubase <= n_ubase; r_wbase <= n_wbase;
        r_vaddr <= n_vaddr;
        r_lenp <= n_lenp; r_lenv <= n_lenv; r_lenl <= n_lenl;
        r_full <= n_full;
        r_odist <= n_odist; r_ofull <= n_ofull;
    end

    assign o_valid               = r_ovalid;
    assign o_distinct_substrings = r_odist;
    assign o_full_res            = r_ofull;

endmodule

// ----- rtl/suffix_automaton_builder.sv -----
// Per symbol: row clear of the new state, first-walk steps (read, then check; the
// walk ends when it passes the root), a compare, then for a clone a row copy,
// second-walk steps and 2 link updates; then the running total and the result load.
// One symbol at a time; row clear and row copy use the transition memory port.
// Dropped symbols go straight to the result load. After reset a pass clears the
// root row; no symbol is accepted meanwhile. New rows are cleared, clone rows copied.
// ----------------------------------------------------------------------------
// suffix_automaton_builder: streaming suffix automaton with substring count
// One symbol in, one running distinct-substring count out per transfer.
// ----------------------------------------------------------------------------
module suffix_automaton_builder
    import sab_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [CW-1:0] i_symbol,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [TW-1:0] o_distinct_substrings,
    output logic          o_full_res
);

    t_cmd  cmd;
    t_stat stat;

    sab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sab_datapath u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_symbol              (i_symbol),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_distinct_substrings (o_distinct_substrings),
        .o_full_res            (o_full_res)
    );

endmodule

// ----- rtl/sab_checker.sv -----
// ----------------------------------------------------------------------------
// sab_port_checker: port-level assertions for the suffix automaton builder
// Checks output hold, one symbol in flight, no ready after reset and a non-decreasing count.
// ----------------------------------------------------------------------------
module sab_port_checker
    import sab_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input logic [TW-1:0] o_distinct_substrings,
    input logic          o_full_res
);

    logic [TW-1:0] r_prev;

    // last delivered count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                r_prev <= '0;
        else if (o_valid && i_ready) r_prev <= o_distinct_substrings;
    end

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distinct_substrings)
            && $stable(o_full_res))
        else $error("stalled result changed");

    // one symbol at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while busy");

    // root row clear follows reset
    a_init: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("ready during reset clear");

    // count never decreases
    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distinct_substrings >= r_prev)
        else $error("count decreased");

endmodule

bind suffix_automaton_builder sab_port_checker u_sab_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_valid               (i_valid),
    .o_ready               (o_ready),
    .o_valid               (o_valid),
    .i_ready               (i_ready),
    .o_distinct_substrings (o_distinct_substrings),
    .o_full_res            (o_full_res)
);
